@@ rtl/audio_downmix_linear_resampler_top_defines.svh @@
// ----------------------------------------------------------------------------
// audio downmix resampler assertion macros
// implication checks that compile away for synthesis
// ----------------------------------------------------------------------------
`ifndef AUDIO_DOWNMIX_LINEAR_RESAMPLER_TOP_DEFINES_SVH
`define AUDIO_DOWNMIX_LINEAR_RESAMPLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ADLR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("adlr assertion failed");
// next-cycle implication
`define ADLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("adlr assertion failed");
`else
`define ADLR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ADLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/adlr_pkg.sv @@
// ----------------------------------------------------------------------------
// adlr_pkg
// shared widths, codes, word type and sequencer states of the resampler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adlr_pkg;

	// field widths
	localparam int PCM_W     = 16;
	localparam int CC_W      = 4;
	localparam int RATE_W    = 18;
	localparam int IDX_W     = 32;
	localparam int LIM_W     = IDX_W + RATE_W;
	localparam int ST_W      = 2;
	localparam int CFG_IDX_W = 2;

	// parameter defaults
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int MAX_RUN_DEF      = 16;

	// register reset values
	localparam logic [CC_W-1:0]   CC_RESET   = 4'd1;
	localparam logic [RATE_W-1:0] RATE_RESET = 18'd16000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_COUNT = 2'd0,
		REG_SRC_RATE      = 2'd1,
		REG_DST_RATE      = 2'd2
	} cfg_reg_t;

	typedef enum logic [ST_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_EMPTY   = 2'd1,
		STATUS_DROPPED = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [PCM_W-1:0] sample;
		logic                    run_end;
		logic                    stream_end;
		status_t                 status;
	} res_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MONO,
		S_LIM_MUL,
		S_LIM_DIV,
		S_LOOP,
		S_REM_MUL,
		S_REM_DIV,
		S_D_MUL,
		S_D_DIV,
		S_PUSH,
		S_REL_DONE,
		S_EOS,
		S_FINAL
	} state_t;

endpackage

@@ rtl/adlr_in_if.sv @@
// ----------------------------------------------------------------------------
// adlr_in_if
// input sample channel: one interleaved pcm sample per word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface adlr_in_if import adlr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [PCM_W-1:0] pcm_sample;
	logic                    end_of_stream;

	modport source (output valid, output pcm_sample, output end_of_stream, input ready);
	modport sink (input valid, input pcm_sample, input end_of_stream, output ready);
endinterface

@@ rtl/adlr_out_if.sv @@
// ----------------------------------------------------------------------------
// adlr_out_if
// result channel: one resampled mono word with flags and status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface adlr_out_if import adlr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [PCM_W-1:0] out_sample;
	logic                    run_end;
	logic                    stream_end;
	logic [ST_W-1:0]         status;

	modport source (output valid, output out_sample, output run_end, output stream_end,
		output status, input ready);
	modport sink (input valid, input out_sample, input run_end, input stream_end,
		input status, output ready);
endinterface

@@ rtl/adlr_cfg_if.sv @@
// ----------------------------------------------------------------------------
// adlr_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface adlr_cfg_if import adlr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [RATE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/audio_downmix_linear_resampler_top.sv @@
// a sample that does not close a frame is accumulated; a closing sample runs the
// mono divide, then the release limit (one serial multiply and one serial divide), then
// per result two serial multiplies and two serial divides.
// one sample is in flight at a time; the serial multiplier and divider set the rate.
// reset clears the stream state and loads channel_count 1 and both rates 16000.
// ----------------------------------------------------------------------------
// audio_downmix_linear_resampler_top
// frame downmix to mono and linear interpolation resampling, bit-serial datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "audio_downmix_linear_resampler_top_defines.svh"

module audio_downmix_linear_resampler_top import adlr_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int MAX_RUN      = MAX_RUN_DEF
) (
	input logic         clk,
	input logic         arst_n,
	adlr_in_if.sink     pcm,
	adlr_out_if.source  res,
	adlr_cfg_if.sink    cfg
);

	localparam int SUM_W = PCM_W + 1 + $clog2(MAX_CHANNELS);
	localparam int POS_W = $clog2(MAX_CHANNELS + 1);
	localparam int RUN_W = $clog2(MAX_RUN + 1);

	state_t state_q, state_d;

	logic [CC_W-1:0]          cc_q;
	logic [RATE_W-1:0]        src_q;
	logic [RATE_W-1:0]        dst_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [PCM_W-1:0]  prev_q;
	logic                     have_prev_q;
	logic [IDX_W-1:0]         mono_idx_q;
	logic [IDX_W-1:0]         idx_q;
	logic [RUN_W-1:0]         run_q;
	logic                     eos_q;
	logic                     phase_q;
	logic                     neg_q;
	logic signed [PCM_W-1:0]  s0_q;
	logic signed [PCM_W-1:0]  s1_q;
	logic [LIM_W-1:0]         lim_q;
	res_word_t                new_q;
	res_word_t                held_q;
	logic                     held_vld_q;
	res_word_t                out_q;
	logic                     out_vld_q;

	logic                     mul_start, mul_done;
	logic [IDX_W-1:0]         mul_a;
	logic [RATE_W-1:0]        mul_b;
	logic [LIM_W-1:0]         mul_prod;
	logic                     div_start, div_done;
	logic [LIM_W-1:0]         div_num;
	logic [RATE_W-1:0]        div_den;
	logic [LIM_W-1:0]         div_quo;
	logic [RATE_W-1:0]        div_rem;

	logic [POS_W-1:0]         ch;
	logic                     rates_ok;
	logic signed [SUM_W-1:0]  sum_nxt;
	logic [SUM_W-1:0]         sum_mag;
	logic [POS_W-1:0]         pos_nxt;
	logic                     frame_done;
	logic                     accept;
	logic                     out_free;
	logic                     idx_lt;
	logic                     run_full;
	logic [PCM_W:0]           diff;
	logic [PCM_W:0]           diff_mag;
	logic [PCM_W-1:0]         q_lo;
	logic [PCM_W-1:0]         mono_val;
	logic [PCM_W-1:0]         interp;
	logic                     out_load;
	res_word_t                out_word;

	// shared serial arithmetic units
	adlr_mul #(.A_W(IDX_W), .B_W(RATE_W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_prod)
	);

	adlr_div #(.N_W(LIM_W), .D_W(RATE_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	// effective channel count
	always_comb begin
		if ({1'b0, cc_q} >= (CC_W + 1)'(MAX_CHANNELS)) begin
			ch = POS_W'(MAX_CHANNELS);
		end else begin
			ch = POS_W'(cc_q);
		end
	end

	// frame accumulation and interpolation terms
	assign rates_ok   = (src_q != '0) && (dst_q != '0);
	assign sum_nxt    = sum_q + SUM_W'(pcm.pcm_sample);
	assign sum_mag    = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
	assign pos_nxt    = pos_q + 1'b1;
	assign frame_done = (ch != '0) && (pos_nxt >= ch);
	assign accept     = pcm.valid && (state_q == S_IDLE);
	assign out_free   = !out_vld_q || res.ready;
	assign idx_lt     = {{RATE_W{1'b0}}, idx_q} < lim_q;
	assign run_full   = run_q >= RUN_W'(MAX_RUN);
	assign diff       = {s1_q[PCM_W-1], s1_q} - {s0_q[PCM_W-1], s0_q};
	assign diff_mag   = diff[PCM_W] ? -diff : diff;
	assign q_lo       = div_quo[PCM_W-1:0];
	assign mono_val   = neg_q ? -q_lo : q_lo;
	assign interp     = s0_q + (diff[PCM_W] ? -q_lo : q_lo);

	// output register load
	always_comb begin
		out_word = held_q;
		out_load = 1'b0;
		if (held_vld_q && out_free && (state_q == S_PUSH || state_q == S_FINAL)) begin
			out_load = 1'b1;
		end
		if (state_q == S_FINAL) begin
			out_word.run_end    = 1'b1;
			out_word.stream_end = eos_q;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and unit strobes
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		mul_a     = mono_idx_q;
		mul_b     = dst_q;
		div_start = 1'b0;
		div_num   = mul_prod;
		div_den   = dst_q;
		case (state_q)
			S_IDLE: begin
				if (pcm.valid) begin
					if (frame_done) begin
						div_start = 1'b1;
						div_num   = LIM_W'(sum_mag);
						div_den   = RATE_W'(ch);
						state_d   = S_MONO;
					end else begin
						state_d = S_EOS;
					end
				end
			end
			S_MONO: begin
				if (div_done) begin
					if (have_prev_q && rates_ok) begin
						mul_start = 1'b1;
						state_d   = S_LIM_MUL;
					end else begin
						state_d = S_REL_DONE;
					end
				end
			end
			S_LIM_MUL: begin
				if (mul_done) begin
					div_start = 1'b1;
					div_den   = src_q;
					state_d   = S_LIM_DIV;
				end
			end
			S_LIM_DIV: begin
				if (div_done) begin
					state_d = S_LOOP;
				end
			end
			S_LOOP: begin
				if (idx_lt && !run_full) begin
					mul_start = 1'b1;
					mul_a     = idx_q;
					mul_b     = src_q;
					state_d   = S_REM_MUL;
				end else begin
					state_d = S_REL_DONE;
				end
			end
			S_REM_MUL: begin
				if (mul_done) begin
					div_start = 1'b1;
					state_d   = S_REM_DIV;
				end
			end
			S_REM_DIV: begin
				if (div_done) begin
					mul_start = 1'b1;
					mul_a     = IDX_W'(diff_mag);
					mul_b     = div_rem;
					state_d   = S_D_MUL;
				end
			end
			S_D_MUL: begin
				if (mul_done) begin
					div_start = 1'b1;
					state_d   = S_D_DIV;
				end
			end
			S_D_DIV: begin
				if (div_done) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				if (!held_vld_q || out_free) begin
					state_d = S_LOOP;
				end
			end
			S_REL_DONE: begin
				state_d = phase_q ? S_FINAL : S_EOS;
			end
			S_EOS: begin
				if (!eos_q || !have_prev_q || !rates_ok) begin
					state_d = S_FINAL;
				end else begin
					mul_start = 1'b1;
					state_d   = S_LIM_MUL;
				end
			end
			S_FINAL: begin
				if (!held_vld_q || out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// configuration registers and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q        <= CC_RESET;
			src_q       <= RATE_RESET;
			dst_q       <= RATE_RESET;
			sum_q       <= '0;
			pos_q       <= '0;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			mono_idx_q  <= '0;
			idx_q       <= '0;
			run_q       <= '0;
			eos_q       <= 1'b0;
			phase_q     <= 1'b0;
			held_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			// register writes
			if (cfg.valid) begin
				case (cfg_reg_t'(cfg.index))
					REG_CHANNEL_COUNT: cc_q  <= cfg.data[CC_W-1:0];
					REG_SRC_RATE:      src_q <= cfg.data;
					REG_DST_RATE:      dst_q <= cfg.data;
					default: ;
				endcase
			end

			// result word handoff
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						eos_q   <= pcm.end_of_stream;
						phase_q <= 1'b0;
						run_q   <= '0;
						if (ch != '0) begin
							if (frame_done) begin
								sum_q <= '0;
								pos_q <= '0;
							end else begin
								sum_q <= sum_nxt;
								pos_q <= pos_nxt;
							end
						end
					end
				end
				S_LOOP: begin
					// cap reached: skip the rest of this run
					if (idx_lt && run_full) begin
						idx_q <= lim_q[IDX_W-1:0];
					end
				end
				S_PUSH: begin
					if (!held_vld_q || out_free) begin
						held_vld_q <= 1'b1;
						run_q      <= run_q + 1'b1;
						idx_q      <= idx_q + 1'b1;
					end
				end
				S_REL_DONE: begin
					if (!phase_q) begin
						prev_q      <= s1_q;
						have_prev_q <= 1'b1;
						mono_idx_q  <= mono_idx_q + 1'b1;
					end
				end
				S_EOS: begin
					if (eos_q) begin
						phase_q <= 1'b1;
						if (!have_prev_q || !rates_ok) begin
							held_vld_q <= 1'b1;
						end
					end
				end
				S_FINAL: begin
					if (!held_vld_q || out_free) begin
						held_vld_q <= 1'b0;
						if (eos_q) begin
							sum_q       <= '0;
							pos_q       <= '0;
							prev_q      <= '0;
							have_prev_q <= 1'b0;
							mono_idx_q  <= '0;
							idx_q       <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		if (accept && frame_done) begin
			neg_q <= sum_nxt[SUM_W-1];
		end
		if (state_q == S_MONO && div_done) begin
			s0_q <= prev_q;
			s1_q <= mono_val;
		end
		if (state_q == S_EOS) begin
			s0_q <= prev_q;
			s1_q <= prev_q;
		end
		if (state_q == S_LIM_DIV && div_done) begin
			lim_q <= div_quo + LIM_W'(div_rem != '0);
		end
		if (state_q == S_D_DIV && div_done) begin
			new_q.sample     <= interp;
			new_q.run_end    <= 1'b0;
			new_q.stream_end <= 1'b0;
			new_q.status     <= STATUS_OK;
		end
		// held word: newest result, or the empty-stream word; marked dropped at the run cap
		if (state_q == S_PUSH && (!held_vld_q || out_free)) begin
			held_q <= new_q;
		end
		if (state_q == S_EOS && eos_q && (!have_prev_q || !rates_ok)) begin
			held_q.sample     <= '0;
			held_q.run_end    <= 1'b0;
			held_q.stream_end <= 1'b0;
			held_q.status     <= STATUS_EMPTY;
		end
		if (state_q == S_LOOP && idx_lt && run_full && held_vld_q) begin
			held_q.status <= STATUS_DROPPED;
		end
		if (out_load) begin
			out_q <= out_word;
		end
	end

	// port drive
	assign pcm.ready      = (state_q == S_IDLE);
	assign cfg.ready      = 1'b1;
	assign res.valid      = out_vld_q;
	assign res.out_sample = out_q.sample;
	assign res.run_end    = out_q.run_end;
	assign res.stream_end = out_q.stream_end;
	assign res.status     = out_q.status;

	// checks
	`ADLR_ASSERT_IMPL(a_run_cap, clk, arst_n, 1'b1, run_q <= RUN_W'(MAX_RUN))
	`ADLR_ASSERT_IMPL(a_end_flags, clk, arst_n, res.valid && res.stream_end, res.run_end)
	`ADLR_ASSERT_IMPL(a_empty_word, clk, arst_n, res.valid && res.status == STATUS_EMPTY, res.stream_end && res.out_sample == '0)
	`ADLR_ASSERT_NEXT(a_final_idle, clk, arst_n, state_q == S_FINAL && out_load, state_q == S_IDLE && !held_vld_q)

endmodule

@@ rtl/adlr_mul.sv @@
// ----------------------------------------------------------------------------
// adlr_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adlr_mul import adlr_pkg::*; #(
	parameter int A_W = IDX_W,
	parameter int B_W = RATE_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] prod
);

	localparam int CNT_W = $clog2(B_W);

	logic [A_W-1:0]   hi_q;
	logic [B_W-1:0]   lo_q;
	logic [A_W-1:0]   a_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [A_W:0]     acc;

	// partial sum for the current multiplier bit
	assign acc = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(B_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// product shift register
	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= b;
			a_q  <= a;
		end else if (busy_q) begin
			hi_q <= acc[A_W:1];
			lo_q <= {acc[0], lo_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

@@ rtl/adlr_div.sv @@
// ----------------------------------------------------------------------------
// adlr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adlr_div import adlr_pkg::*; #(
	parameter int N_W = LIM_W,
	parameter int D_W = RATE_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           done,
	output logic [N_W-1:0] quo,
	output logic [D_W-1:0] rem
);

	localparam int CNT_W = $clog2(N_W);

	logic [N_W-1:0]   num_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             ge;

	// trial subtract of the next dividend bit
	assign trial = {rem_q, num_q[N_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// dividend shifts out, quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
			num_q <= {num_q[N_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = num_q;
	assign rem  = rem_q;

endmodule
